// ===== hw/rtl/scfea_pkg.sv =====
package scfea_pkg;

  localparam int START_W  = 48;
  localparam int LEN_W    = 32;
  localparam int AGE_W    = 32;
  localparam int STATUS_W = 3;

  localparam int TABLE_ENTRIES_DEF = 64;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  localparam logic [STATUS_W-1:0] ST_ADDED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ALLOC = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOFIT = 3'd4;

  // One stored extent.
  typedef struct packed {
    logic [LEN_W-1:0]   length;
    logic [START_W-1:0] start;
    logic [AGE_W-1:0]   age;
  } entry_t;

  // Outcome of a table scan, apart from the slot indices.
  typedef struct packed {
    logic               free_found;
    logic               exact_found;
    logic [START_W-1:0] exact_start;
    logic               larger_found;
    logic [LEN_W-1:0]   larger_len;
    logic [START_W-1:0] larger_start;
  } sel_t;

endpackage

// ===== hw/rtl/scfea_ifs.sv =====
interface scfea_req_if import scfea_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               op;
  logic [START_W-1:0] extent_start;
  logic [LEN_W-1:0]   extent_length;

  modport source (output valid, op, extent_start, extent_length, input ready);
  modport sink (input valid, op, extent_start, extent_length, output ready);
endinterface

interface scfea_rsp_if import scfea_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [START_W-1:0]  alloc_start;

  modport source (output valid, status, alloc_start, input ready);
  modport sink (input valid, status, alloc_start, output ready);
endinterface

// ===== hw/rtl/size_class_free_extent_allocator_top.sv =====
// One request at a time: a new one is taken only once the last result has been taken.
// The table is read one slot a cycle through a single memory port and every request
// scans the whole table.
// Reset (synchronous, rst high) empties the table, zeroes the age counter and leaves
// the block ready; no clearing pass is needed since occupancy lives in flip-flops.
module size_class_free_extent_allocator_top import scfea_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input logic        clk,
  input logic        rst,
  scfea_req_if.sink  req,
  scfea_rsp_if.source rsp
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_FINISH = 3'd3;
  localparam logic [2:0] S_RESP   = 3'd4;

  logic [2:0]         state;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   rd_idx;
  logic               consume;
  logic [AGE_W-1:0]   age_counter;

  // The request is held for the whole scan.
  logic               op_q;
  logic [START_W-1:0] start_q;
  logic [LEN_W-1:0]   len_q;

  entry_t             rd_entry;
  logic               rd_valid;
  sel_t               sel;
  logic [IDX_W-1:0]   free_idx;
  logic [IDX_W-1:0]   exact_idx;
  logic [IDX_W-1:0]   larger_idx;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;
  logic               clr_en;
  logic [STATUS_W-1:0] status_next;
  logic [START_W-1:0] result_next;

  logic               accept;
  logic               scan_last;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign scan_last = (idx == IDX_W'(TABLE_ENTRIES - 1));

  // The table is read at the scan counter; its data comes back registered in the next cycle,
  // which is when the selection unit looks at it together with the delayed index.
  scfea_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IDX_W         (IDX_W)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (idx),
    .rd_entry (rd_entry),
    .rd_valid (rd_valid),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .clr_en   (clr_en),
    .clr_addr (exact_idx)
  );

  // The selection unit is the one shared compare engine: it sees a single slot a
  // cycle and keeps the first free slot, the most recent exact fit and the most
  // recent extent of the smallest larger length.
  scfea_select #(
    .IDX_W (IDX_W)
  ) u_select (
    .clk        (clk),
    .rst        (rst),
    .clear      (accept),
    .consume    (consume),
    .rd_valid   (rd_valid),
    .rd_entry   (rd_entry),
    .rd_idx     (rd_idx),
    .req_len    (len_q),
    .age_now    (age_counter),
    .sel        (sel),
    .free_idx   (free_idx),
    .exact_idx  (exact_idx),
    .larger_idx (larger_idx)
  );

  // Decision once the scan is over. An add files the extent in the first free
  // slot. An allocation takes an exact fit outright, or else splits the chosen
  // larger extent and files the remainder in the same slot as the newest entry.
  // Zero lengths change nothing in either case.
  always_comb begin
    wr_en       = 1'b0;
    wr_addr     = free_idx;
    wr_data     = '{length: len_q, start: start_q, age: age_counter};
    clr_en      = 1'b0;
    result_next = '0;
    status_next = ST_NOFIT;
    if (op_q == OP_ADD) begin
      priority if (len_q == '0) begin
        status_next = ST_ZERO;
      end else if (!sel.free_found) begin
        status_next = ST_FULL;
      end else begin
        status_next = ST_ADDED;
        wr_en       = (state == S_FINISH);
      end
    end else begin
      priority if (len_q == '0) begin
        status_next = ST_NOFIT;
      end else if (sel.exact_found) begin
        status_next = ST_ALLOC;
        result_next = sel.exact_start;
        clr_en      = (state == S_FINISH);
      end else if (sel.larger_found) begin
        status_next = ST_ALLOC;
        result_next = sel.larger_start;
        wr_en       = (state == S_FINISH);
        wr_addr     = larger_idx;
        wr_data     = '{length: sel.larger_len - len_q,
                        start:  sel.larger_start + START_W'(len_q),
                        age:    age_counter};
      end else begin
        status_next = ST_NOFIT;
      end
    end
  end

  // Sequencer: idle, scan every slot, let the last read land, decide, answer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      consume     <= 1'b0;
      age_counter <= '0;
      rsp.valid   <= 1'b0;
    end else begin
      consume <= (state == S_SCAN);
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          state     <= S_RESP;
          rsp.valid <= 1'b1;
          if (wr_en) begin
            age_counter <= age_counter + 1'b1;
          end
        end
        S_RESP: begin
          if (rsp.ready) begin
            state     <= S_IDLE;
            rsp.valid <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload and counters that need no reset.
  always_ff @(posedge clk) begin
    rd_idx <= idx;
    if (accept) begin
      op_q    <= req.op;
      start_q <= req.extent_start;
      len_q   <= req.extent_length;
      idx     <= '0;
    end else if (state == S_SCAN && !scan_last) begin
      idx <= idx + 1'b1;
    end
    if (state == S_FINISH) begin
      rsp.status      <= status_next;
      rsp.alloc_start <= result_next;
    end
  end

endmodule

// ===== hw/rtl/scfea_table.sv =====
module scfea_table import scfea_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int IDX_W         = $clog2(TABLE_ENTRIES)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_entry,
  output logic             rd_valid,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  entry_t           wr_data,
  input  logic             clr_en,
  input  logic [IDX_W-1:0] clr_addr
);

  entry_t                   mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid;

  // Extent storage: one write and one registered read each cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_entry <= mem[rd_addr];
  end

  // Occupancy flags, cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (clr_en) begin
        valid[clr_addr] <= 1'b0;
      end
      rd_valid <= valid[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/scfea_select.sv =====
module scfea_select import scfea_pkg::*; #(
  parameter int IDX_W = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             clear,
  input  logic             consume,
  input  logic             rd_valid,
  input  entry_t           rd_entry,
  input  logic [IDX_W-1:0] rd_idx,
  input  logic [LEN_W-1:0] req_len,
  input  logic [AGE_W-1:0] age_now,
  output sel_t             sel,
  output logic [IDX_W-1:0] free_idx,
  output logic [IDX_W-1:0] exact_idx,
  output logic [IDX_W-1:0] larger_idx
);

  logic [AGE_W-1:0] exact_dist;
  logic [AGE_W-1:0] larger_dist;
  logic [AGE_W-1:0] age_gap;
  logic             len_eq;
  logic             len_gt;
  logic             take_exact;
  logic             take_larger;

  // Age distance of the entry under inspection; smaller means more recent.
  assign age_gap = age_now - rd_entry.age;
  assign len_eq  = (rd_entry.length == req_len);
  assign len_gt  = (rd_entry.length > req_len);

  // Strict comparisons keep the lowest slot on a tie.
  always_comb begin
    take_exact  = rd_valid && len_eq && (!sel.exact_found || (age_gap < exact_dist));
    take_larger = rd_valid && len_gt &&
                  (!sel.larger_found || (rd_entry.length < sel.larger_len) ||
                   ((rd_entry.length == sel.larger_len) && (age_gap < larger_dist)));
  end

  // The found flags are cleared for each request; the captured slot data
  // needs no reset since it is only looked at behind its flag.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      sel.free_found   <= 1'b0;
      sel.exact_found  <= 1'b0;
      sel.larger_found <= 1'b0;
    end else if (consume) begin
      if (!rd_valid && !sel.free_found) begin
        sel.free_found <= 1'b1;
        free_idx       <= rd_idx;
      end
      if (take_exact) begin
        sel.exact_found <= 1'b1;
        exact_idx       <= rd_idx;
        exact_dist      <= age_gap;
        sel.exact_start <= rd_entry.start;
      end
      if (take_larger) begin
        sel.larger_found <= 1'b1;
        larger_idx       <= rd_idx;
        larger_dist      <= age_gap;
        sel.larger_len   <= rd_entry.length;
        sel.larger_start <= rd_entry.start;
      end
    end
  end

endmodule

// ===== hw/rtl/scfea_checker.sv =====
module scfea_checker import scfea_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [STATUS_W-1:0] status,
  input logic [START_W-1:0]  alloc_start
);

  // A pending result is held until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(alloc_start))
    else $error("result changed or dropped while stalled");

  // One item at a time: no new request while a result is outstanding.
  assert property (@(posedge clk) disable iff (rst) !(req_ready && rsp_valid))
    else $error("ready while a result is pending");

  // After an accepted request the block is busy scanning.
  assert property (@(posedge clk) disable iff (rst) req_valid && req_ready |=> !req_ready)
    else $error("ready straight after an accepted request");

  // Only defined status codes appear.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (status == ST_ADDED || status == ST_ZERO || status == ST_FULL ||
                   status == ST_ALLOC || status == ST_NOFIT))
    else $error("undefined status code");

  // A start position is only reported for an allocation.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != ST_ALLOC) |-> (alloc_start == '0))
    else $error("start position reported without allocation");

endmodule

bind size_class_free_extent_allocator_top scfea_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .status      (rsp.status),
  .alloc_start (rsp.alloc_start)
);
